[rtl/rrba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rrba_pkg;

    localparam int WIDTH  = 32;
    localparam int VAL_W  = WIDTH - 1;
    localparam int PROD_W = 2 * WIDTH;
    localparam int CNT_W  = $clog2(WIDTH) + 1;

    typedef struct packed {
        logic signed [WIDTH-1:0] num_in;
        logic signed [WIDTH-1:0] den_in;
    } in_item_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] num_out;
        logic        [VAL_W-1:0] den_out;
        logic                    exact;
    } out_item_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_TWOS,
        CMD_ODDA,
        CMD_STEP,
        CMD_GFIN,
        CMD_DIV_AG,
        CMD_DIV_RG,
        CMD_DIV_AR,
        CMD_DIV_PX,
        CMD_DIV_QY,
        CMD_CAP_A,
        CMD_CAP_R,
        CMD_CAP_X,
        CMD_CAP_XS,
        CMD_CAP_Y,
        CMD_SHORT,
        CMD_MUL_P,
        CMD_MUL_Q,
        CMD_SUM,
        CMD_ADV,
        CMD_T,
        CMD_MUL_L,
        CMD_MUL_R,
        CMD_SEMI
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic a_zero;
        logic r_zero;
        logic both_even;
        logic ga_odd;
        logic gb_zero;
        logic g_zero;
        logic fit;
        logic over;
        logic p1_zero;
        logic q1_zero;
        logic div_done;
    } status_t;

endpackage
`default_nettype wire

[rtl/rrba_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module rrba_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [rrba_pkg::WIDTH-1:0] dividend,
    input  wire logic [rrba_pkg::WIDTH-1:0] divisor,
    output logic                            done,
    output logic      [rrba_pkg::WIDTH-1:0] quo,
    output logic      [rrba_pkg::WIDTH-1:0] rem
);
    import rrba_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[WIDTH-1]};
        diff      = shifted - {1'b0, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[WIDTH]) begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

[rtl/rrba_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module rrba_dp (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [rrba_pkg::VAL_W-1:0] cfg_wr_data,
    input  wire rrba_pkg::in_item_t         in_item,
    input  wire rrba_pkg::cmd_t             cmd,
    output rrba_pkg::status_t               status,
    output rrba_pkg::out_item_t             result
);
    import rrba_pkg::*;

    logic [VAL_W-1:0]  max_reg;
    logic [VAL_W-1:0]  mx;
    logic [WIDTH-1:0]  a_reg, r_reg, nr_reg, ga_reg, gb_reg, g_reg, x_reg, t_reg;
    logic [VAL_W-1:0]  p0_reg, q0_reg, p1_reg, q1_reg;
    logic [CNT_W-1:0]  twos_reg;
    logic              sign_reg;
    logic [PROD_W-1:0] prodp_reg, prodq_reg, p2_reg, q2_reg;
    logic [WIDTH-1:0]  mag_n, mag_d;
    logic              div_start, div_done;
    logic [WIDTH-1:0]  div_n, div_d, div_q, div_r;
    logic [WIDTH-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [WIDTH-1:0]  num_pos;

    assign mx    = (max_reg == '0) ? VAL_W'(1) : max_reg;
    assign mag_n = in_item.num_in[WIDTH-1] ? (~in_item.num_in + 1'b1) : in_item.num_in;
    assign mag_d = in_item.den_in[WIDTH-1] ? (~in_item.den_in + 1'b1) : in_item.den_in;

    always_comb begin
        div_start = 1'b1;
        div_n     = a_reg;
        div_d     = g_reg;
        case (cmd)
            CMD_DIV_AG: begin div_n = a_reg; div_d = g_reg; end
            CMD_DIV_RG: begin div_n = r_reg; div_d = g_reg; end
            CMD_DIV_AR: begin div_n = a_reg; div_d = r_reg; end
            CMD_DIV_PX: begin
                div_n = {1'b0, mx} - {1'b0, p0_reg};
                div_d = {1'b0, p1_reg};
            end
            CMD_DIV_QY: begin
                div_n = {1'b0, mx} - {1'b0, q0_reg};
                div_d = {1'b0, q1_reg};
            end
            default: div_start = 1'b0;
        endcase
    end

    rrba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quo      (div_q),
        .rem      (div_r)
    );

    always_comb begin
        mul_a = x_reg;
        mul_b = {1'b0, p1_reg};
        case (cmd)
            CMD_MUL_Q: begin mul_a = x_reg; mul_b = {1'b0, q1_reg}; end
            CMD_MUL_L: begin mul_a = r_reg; mul_b = t_reg; end
            CMD_MUL_R: begin mul_a = a_reg; mul_b = {1'b0, q1_reg}; end
            default: begin mul_a = x_reg; mul_b = {1'b0, p1_reg}; end
        endcase
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= {VAL_W{1'b1}};
        end else if (cfg_wr_en) begin
            max_reg <= cfg_wr_data;
        end
        case (cmd) inside
            CMD_LOAD: begin
                a_reg    <= mag_n;
                r_reg    <= mag_d;
                ga_reg   <= mag_n;
                gb_reg   <= mag_d;
                twos_reg <= '0;
                sign_reg <= in_item.num_in[WIDTH-1] ^ in_item.den_in[WIDTH-1];
                p0_reg   <= '0;
                q0_reg   <= VAL_W'(1);
                p1_reg   <= VAL_W'(1);
                q1_reg   <= '0;
            end
            CMD_TWOS: begin
                if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_reg   <= ga_reg >> 1;
                    gb_reg   <= gb_reg >> 1;
                    twos_reg <= twos_reg + 1'b1;
                end
            end
            CMD_ODDA: begin
                if (!ga_reg[0]) ga_reg <= ga_reg >> 1;
            end
            CMD_STEP: begin
                if (!gb_reg[0]) begin
                    gb_reg <= gb_reg >> 1;
                end else if (ga_reg > gb_reg) begin
                    ga_reg <= gb_reg;
                    gb_reg <= ga_reg - gb_reg;
                end else begin
                    gb_reg <= gb_reg - ga_reg;
                end
            end
            CMD_GFIN: begin
                if (a_reg == '0)      g_reg <= r_reg;
                else if (r_reg == '0) g_reg <= a_reg;
                else                  g_reg <= ga_reg << twos_reg;
            end
            CMD_CAP_A:  a_reg <= div_q;
            CMD_CAP_R:  r_reg <= div_q;
            CMD_CAP_X: begin
                x_reg  <= div_q;
                nr_reg <= div_r;
            end
            CMD_CAP_XS: x_reg <= div_q;
            CMD_CAP_Y: begin
                if (div_q < x_reg) x_reg <= div_q;
            end
            CMD_SHORT: begin
                p1_reg <= a_reg[VAL_W-1:0];
                q1_reg <= r_reg[VAL_W-1:0];
                r_reg  <= '0;
            end
            CMD_MUL_P, CMD_MUL_L: prodp_reg <= mul_p;
            CMD_MUL_Q, CMD_MUL_R: prodq_reg <= mul_p;
            CMD_SUM: begin
                p2_reg <= prodp_reg + PROD_W'(p0_reg);
                q2_reg <= prodq_reg + PROD_W'(q0_reg);
            end
            CMD_ADV: begin
                p0_reg <= p1_reg;
                q0_reg <= q1_reg;
                p1_reg <= p2_reg[VAL_W-1:0];
                q1_reg <= q2_reg[VAL_W-1:0];
                a_reg  <= r_reg;
                r_reg  <= nr_reg;
            end
            CMD_T: t_reg <= {prodq_reg[WIDTH-2:0], 1'b0} + {1'b0, q0_reg};
            CMD_SEMI: begin
                // Take the semiconvergent only when it lies strictly closer.
                if (prodp_reg > prodq_reg) begin
                    p1_reg <= p2_reg[VAL_W-1:0];
                    q1_reg <= q2_reg[VAL_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        status.a_zero    = (a_reg == '0);
        status.r_zero    = (r_reg == '0);
        status.both_even = !ga_reg[0] && !gb_reg[0];
        status.ga_odd    = ga_reg[0];
        status.gb_zero   = (gb_reg == '0);
        status.g_zero    = (g_reg == '0);
        status.fit       = (a_reg <= {1'b0, mx}) && (r_reg <= {1'b0, mx});
        status.over      = (p2_reg > PROD_W'(mx)) || (q2_reg > PROD_W'(mx));
        status.p1_zero   = (p1_reg == '0);
        status.q1_zero   = (q1_reg == '0);
        status.div_done  = div_done;
    end

    assign num_pos        = {1'b0, p1_reg};
    assign result.num_out = sign_reg ? (~num_pos + 1'b1) : num_pos;
    assign result.den_out = q1_reg;
    assign result.exact   = (r_reg == '0);

endmodule
`default_nettype wire

[rtl/rrba_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module rrba_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                out_free,
    input  wire rrba_pkg::status_t   status,
    output rrba_pkg::ctrl_t          ctrl
);
    import rrba_pkg::*;

    typedef enum logic [26:0] {
        S_IDLE = 27'd1 << 0,
        S_ZCHK = 27'd1 << 1,
        S_TWOS = 27'd1 << 2,
        S_ODDA = 27'd1 << 3,
        S_STEP = 27'd1 << 4,
        S_GFIN = 27'd1 << 5,
        S_DIVA = 27'd1 << 6,
        S_WA   = 27'd1 << 7,
        S_DIVR = 27'd1 << 8,
        S_WR   = 27'd1 << 9,
        S_FIT  = 27'd1 << 10,
        S_LOOP = 27'd1 << 11,
        S_WX   = 27'd1 << 12,
        S_MP   = 27'd1 << 13,
        S_MQ   = 27'd1 << 14,
        S_SUM  = 27'd1 << 15,
        S_CHK  = 27'd1 << 16,
        S_SP   = 27'd1 << 17,
        S_WP   = 27'd1 << 18,
        S_SQ   = 27'd1 << 19,
        S_WQ   = 27'd1 << 20,
        S_SMP  = 27'd1 << 21,
        S_SMQ  = 27'd1 << 22,
        S_SSUM = 27'd1 << 23,
        S_ST   = 27'd1 << 24,
        S_SML  = 27'd1 << 25,
        S_SEL  = 27'd1 << 26
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb begin
        state_next    = state_reg;
        done_next     = done_reg;
        ctrl.cmd      = CMD_NONE;
        ctrl.out_load = 1'b0;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (done_reg) begin
                    if (out_free) begin
                        ctrl.out_load = 1'b1;
                        done_next     = 1'b0;
                    end
                end else begin
                    in_ready = 1'b1;
                    if (in_valid) begin
                        ctrl.cmd   = CMD_LOAD;
                        state_next = S_ZCHK;
                    end
                end
            end
            S_ZCHK: state_next = (status.a_zero || status.r_zero) ? S_GFIN : S_TWOS;
            S_TWOS: begin
                ctrl.cmd = CMD_TWOS;
                if (!status.both_even) state_next = S_ODDA;
            end
            S_ODDA: begin
                ctrl.cmd = CMD_ODDA;
                if (status.ga_odd) state_next = S_STEP;
            end
            S_STEP: begin
                ctrl.cmd = CMD_STEP;
                if (status.gb_zero) state_next = S_GFIN;
            end
            S_GFIN: begin
                ctrl.cmd   = CMD_GFIN;
                state_next = S_DIVA;
            end
            S_DIVA: begin
                if (status.g_zero) begin
                    state_next = S_FIT;
                end else begin
                    ctrl.cmd   = CMD_DIV_AG;
                    state_next = S_WA;
                end
            end
            S_WA: begin
                if (status.div_done) begin
                    ctrl.cmd   = CMD_CAP_A;
                    state_next = S_DIVR;
                end
            end
            S_DIVR: begin
                ctrl.cmd   = CMD_DIV_RG;
                state_next = S_WR;
            end
            S_WR: begin
                if (status.div_done) begin
                    ctrl.cmd   = CMD_CAP_R;
                    state_next = S_FIT;
                end
            end
            S_FIT: begin
                if (status.fit) begin
                    ctrl.cmd   = CMD_SHORT;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end else begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (status.r_zero) begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end else begin
                    ctrl.cmd   = CMD_DIV_AR;
                    state_next = S_WX;
                end
            end
            S_WX: begin
                if (status.div_done) begin
                    ctrl.cmd   = CMD_CAP_X;
                    state_next = S_MP;
                end
            end
            S_MP: begin
                ctrl.cmd   = CMD_MUL_P;
                state_next = S_MQ;
            end
            S_MQ: begin
                ctrl.cmd   = CMD_MUL_Q;
                state_next = S_SUM;
            end
            S_SUM: begin
                ctrl.cmd   = CMD_SUM;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (status.over) begin
                    state_next = S_SP;
                end else begin
                    ctrl.cmd   = CMD_ADV;
                    state_next = S_LOOP;
                end
            end
            S_SP: begin
                if (status.p1_zero) begin
                    state_next = S_SQ;
                end else begin
                    ctrl.cmd   = CMD_DIV_PX;
                    state_next = S_WP;
                end
            end
            S_WP: begin
                if (status.div_done) begin
                    ctrl.cmd   = CMD_CAP_XS;
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                if (status.q1_zero) begin
                    state_next = S_SMP;
                end else begin
                    ctrl.cmd   = CMD_DIV_QY;
                    state_next = S_WQ;
                end
            end
            S_WQ: begin
                if (status.div_done) begin
                    ctrl.cmd   = CMD_CAP_Y;
                    state_next = S_SMP;
                end
            end
            S_SMP: begin
                ctrl.cmd   = CMD_MUL_P;
                state_next = S_SMQ;
            end
            S_SMQ: begin
                ctrl.cmd   = CMD_MUL_Q;
                state_next = S_SSUM;
            end
            S_SSUM: begin
                ctrl.cmd   = CMD_SUM;
                state_next = S_ST;
            end
            S_ST: begin
                ctrl.cmd   = CMD_T;
                state_next = S_SML;
            end
            S_SML: begin
                ctrl.cmd   = CMD_MUL_L;
                state_next = S_SEL;
            end
            S_SEL: begin
                if (done_reg) begin
                    ctrl.cmd   = CMD_SEMI;
                    state_next = S_IDLE;
                end else begin
                    // First pass loads the second product; second pass selects.
                    ctrl.cmd  = CMD_MUL_R;
                    done_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule
`default_nettype wire

[rtl/rational_reduce_best_approx.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  in_item_t  {num_in, den_in}
// m_        out        m_valid / m_ready  out_item_t {num_out, den_out, exact}
// cfg_      in         cfg_wr_en          max_value (31 bits), no read-back
//
// One item is worked at a time. The binary GCD takes one shift or subtract per
// cycle, each reduction divide runs in the shared restoring divider, and every
// continued-fraction term costs a divide, two multiplies and a sum.
// Reset is synchronous and active low; it restores max_value to all ones.
// A finished result waits in the output register while the next item is taken in.
module rational_reduce_best_approx (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [rrba_pkg::VAL_W-1:0] cfg_wr_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire rrba_pkg::in_item_t         s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output rrba_pkg::out_item_t             m_data
);
    import rrba_pkg::*;

    ctrl_t     ctrl;
    status_t   status;
    out_item_t result;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;
    logic      out_free;

    // The output slot is free when empty or being emptied in this cycle.
    assign out_free = !m_valid_reg || m_ready;

    // The controller sequences the GCD, the reductions and the continued fraction.
    rrba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl)
    );

    // The datapath holds the working registers, the divider and the multiplier.
    rrba_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (s_data),
        .cmd         (ctrl.cmd),
        .status      (status),
        .result      (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (ctrl.out_load)          m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (ctrl.out_load) m_data_reg <= result;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire
